// ===== sv/bwa_pkg.sv =====
package bwa_pkg;

   localparam int unsigned WINDOW_DEF = 8;

   localparam int unsigned SAMPLE_W = 13;
   localparam int unsigned DATA_W   = 12;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned AVG_W    = 12;
   localparam int unsigned THRESH_W = 12;

   localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 12'd2048;

   localparam logic [STATUS_W-1:0] STATUS_NOT_READY = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_LOW       = 2'd2;

   // response queue; also the number of requests that may be outstanding
   localparam int unsigned RSP_DEPTH = 8;
   localparam int unsigned RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int unsigned RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic valid;
      logic clear;
      logic full;
   } win_ctrl_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [AVG_W-1:0]    average;
   } rsp_item_type;

endpackage

// ===== sv/bwa_if.sv =====
interface bwa_req_if;
   import bwa_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface bwa_rsp_if;
   import bwa_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [AVG_W-1:0]    average;
   modport source (output valid, output status, output average, input ready);
   modport sink (input valid, input status, input average, output ready);
endinterface

interface bwa_csr_if;
   import bwa_pkg::*;
   logic                valid;
   logic                ready;
   logic [THRESH_W-1:0] charge_ok_threshold;
   modport source (output valid, output charge_ok_threshold, input ready);
   modport sink (input valid, input charge_ok_threshold, output ready);
endinterface

// ===== sv/bwa_window.sv =====
module bwa_window #(
   parameter int unsigned WINDOW = bwa_pkg::WINDOW_DEF,
   localparam int unsigned SUM_W = bwa_pkg::SAMPLE_W - 1 + $clog2(WINDOW)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic signed [bwa_pkg::SAMPLE_W-1:0] sample,
   output bwa_pkg::win_ctrl_type               ctrl,
   output logic [SUM_W-1:0]                    sum
);
   import bwa_pkg::*;

   localparam int unsigned PTR_W = $clog2(WINDOW);

   logic [DATA_W-1:0] mem [WINDOW];

   logic [PTR_W-1:0]  pos_ff, pos_in;
   logic              full_ff, full_in;
   logic [DATA_W-1:0] rd_ff;

   logic              s1_valid_ff;
   logic              s1_clear_ff;
   logic              s1_sub_ff;
   logic              s1_full_ff;
   logic [PTR_W-1:0]  s1_pos_ff;
   logic [DATA_W-1:0] s1_data_ff;

   logic [SUM_W-1:0]  sum_ff, sum_in;
   win_ctrl_type      ctrl_ff, ctrl_in;

   logic positive;
   logic wrap;

   assign positive = !sample[SAMPLE_W-1] && (sample != '0);
   assign wrap     = (pos_ff == PTR_W'(WINDOW - 1));

   always_comb begin
      pos_in  = pos_ff;
      full_in = full_ff;
      if (in_valid) begin
         if (!positive) begin
            pos_in  = '0;
            full_in = 1'b0;
         end else begin
            pos_in  = wrap ? '0 : pos_ff + PTR_W'(1);
            full_in = full_ff | wrap;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         full_ff     <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         full_ff     <= full_in;
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      s1_clear_ff <= !positive;
      s1_sub_ff   <= full_ff;
      s1_full_ff  <= full_in;
      s1_pos_ff   <= pos_ff;
      s1_data_ff  <= sample[DATA_W-1:0];
   end

   // Read the entry about to be overwritten; the write lands in the following cycle.
   // The next read is at least one position ahead, so no bypass is needed.
   always_ff @(posedge clock) begin
      rd_ff <= mem[pos_ff];
      if (s1_valid_ff && !s1_clear_ff) begin
         mem[s1_pos_ff] <= s1_data_ff;
      end
   end

   always_comb begin
      sum_in        = sum_ff;
      ctrl_in.valid = s1_valid_ff;
      ctrl_in.clear = s1_clear_ff;
      ctrl_in.full  = s1_full_ff;
      if (s1_valid_ff) begin
         if (s1_clear_ff) begin
            sum_in = '0;
         end else begin
            sum_in = sum_ff
                   - (s1_sub_ff ? SUM_W'(rd_ff) : '0)
                   + SUM_W'(s1_data_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         ctrl_ff <= '0;
      end else begin
         sum_ff  <= sum_in;
         ctrl_ff <= ctrl_in;
      end
   end

   assign ctrl = ctrl_ff;
   assign sum  = sum_ff;

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_clear_ff) |-> (s1_pos_ff != pos_ff))
      else $error("window write collides with pending read");

endmodule

// ===== sv/bwa_average.sv =====
module bwa_average #(
   parameter int unsigned WINDOW = bwa_pkg::WINDOW_DEF,
   localparam int unsigned SUM_W = bwa_pkg::SAMPLE_W - 1 + $clog2(WINDOW)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  bwa_pkg::win_ctrl_type           ctrl,
   input  logic [SUM_W-1:0]                sum,
   input  logic [bwa_pkg::THRESH_W-1:0]    threshold,
   output logic                            push,
   output bwa_pkg::rsp_item_type           item
);
   import bwa_pkg::*;

   // floor(sum / WINDOW) as (sum * ceil(2^SHIFT / WINDOW)) >> SHIFT, exact
   // for every SUM_W-bit sum
   localparam int unsigned LOG_W   = $clog2(WINDOW);
   localparam int unsigned SHIFT   = SUM_W + LOG_W;
   localparam int unsigned RECIP_W = SUM_W + 1;
   localparam int unsigned PROD_W  = SUM_W + RECIP_W;
   localparam longint unsigned RECIP_L =
      ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

   logic [PROD_W-1:0]   prod_ff;
   win_ctrl_type        c2_ff;
   logic [STATUS_W-1:0] level_ff, level_in;
   logic [AVG_W-1:0]    avg;
   logic                hit;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(sum) * PROD_W'(RECIP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c2_ff <= '0;
      end else begin
         c2_ff <= ctrl;
      end
   end

   assign avg = prod_ff[SHIFT +: AVG_W];
   assign hit = c2_ff.valid && !c2_ff.clear && c2_ff.full;

   always_comb begin
      level_in = level_ff;
      if (hit) begin
         level_in = (avg >= threshold) ? STATUS_OK : STATUS_LOW;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= STATUS_NOT_READY;
      end else begin
         level_ff <= level_in;
      end
   end

   assign push         = c2_ff.valid;
   assign item.status  = level_in;
   assign item.average = hit ? avg : '0;

   a_level_sticky: assert property (@(posedge clock) disable iff (reset)
      (level_ff != STATUS_NOT_READY) |=> (level_ff != STATUS_NOT_READY))
      else $error("status fell back to not ready");

endmodule

// ===== sv/bwa_rsp_fifo.sv =====
module bwa_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  bwa_pkg::rsp_item_type item_in,
   input  logic                  pop,
   output logic                  out_valid,
   output bwa_pkg::rsp_item_type item_out
);
   import bwa_pkg::*;

   rsp_item_type entry_ff [RSP_DEPTH];

   logic [RSP_PTR_W-1:0] wr_ff, rd_ff;
   logic [RSP_CNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + RSP_PTR_W'(1);
         end
         if (pop) begin
            rd_ff <= rd_ff + RSP_PTR_W'(1);
         end
         count_ff <= count_ff + RSP_CNT_W'(push) - RSP_CNT_W'(pop);
      end
   end

   assign out_valid = (count_ff != '0);
   assign item_out  = entry_ff[rd_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> (count_ff != RSP_CNT_W'(RSP_DEPTH)))
      else $error("response queue overflow");

endmodule

// ===== sv/battery_level_window_average.sv =====
// channel   dir  handshake            payload
// req_ch    in   valid/ready          sample (13b signed)
// rsp_ch    out  valid/ready          status (2b), average (12b)
// csr_ch    in   valid/ready (=1)     charge_ok_threshold (12b)
//
// One request per cycle while req_ch.ready is high; each result passes through
// the window RAM read, running-sum update and reciprocal multiply, then the queue.
// Up to RSP_DEPTH requests may be outstanding; req_ch.ready drops when
// that many results are in flight or waiting, so rsp stalls backpressure.
// Synchronous reset; the sample RAM is not cleared and needs no sweep.
module battery_level_window_average #(
   parameter int unsigned WINDOW = bwa_pkg::WINDOW_DEF
) (
   input logic        clock,
   input logic        reset,
   bwa_req_if.sink    req_ch,
   bwa_rsp_if.source  rsp_ch,
   bwa_csr_if.sink    csr_ch
);
   import bwa_pkg::*;

   localparam int unsigned SUM_W = SAMPLE_W - 1 + $clog2(WINDOW);

   logic [THRESH_W-1:0]  threshold_ff;
   logic [RSP_CNT_W-1:0] pend_ff, pend_in;
   logic                 req_acc;
   logic                 rsp_pop;

   win_ctrl_type         win_ctrl;
   logic [SUM_W-1:0]     win_sum;
   logic                 push;
   rsp_item_type         push_item;
   rsp_item_type         head_item;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_ch.valid) begin
         threshold_ff <= csr_ch.charge_ok_threshold;
      end
   end

   assign req_ch.ready = (pend_ff != RSP_CNT_W'(RSP_DEPTH));
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign rsp_pop      = rsp_ch.valid && rsp_ch.ready;
   assign pend_in      = pend_ff + RSP_CNT_W'(req_acc) - RSP_CNT_W'(rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   bwa_window #(.WINDOW(WINDOW)) u_window (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_acc),
      .sample   (req_ch.sample),
      .ctrl     (win_ctrl),
      .sum      (win_sum)
   );

   bwa_average #(.WINDOW(WINDOW)) u_average (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (win_ctrl),
      .sum       (win_sum),
      .threshold (threshold_ff),
      .push      (push),
      .item      (push_item)
   );

   bwa_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .item_in   (push_item),
      .pop       (rsp_pop),
      .out_valid (rsp_ch.valid),
      .item_out  (head_item)
   );

   assign rsp_ch.status  = head_item.status;
   assign rsp_ch.average = head_item.average;

endmodule
